### rtl/core/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg - shared types and constants of the identifier case restyler
// character codes, style codes, the queue entry and case mapping helpers
// ----------------------------------------------------------------------------
package icr_pkg;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0    = 8'h30;
	localparam logic [7:0] CH_DIGIT_9    = 8'h39;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_HYPHEN     = 8'h2D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	localparam logic [2:0] STYLE_CAMEL     = 3'd0;
	localparam logic [2:0] STYLE_PASCAL    = 3'd1;
	localparam logic [2:0] STYLE_SNAKE     = 3'd2;
	localparam logic [2:0] STYLE_KEBAB     = 3'd3;
	localparam logic [2:0] STYLE_SCREAMING = 3'd4;
	localparam logic [2:0] STYLE_TITLE     = 3'd5;
	localparam logic [2:0] STYLE_LOWER     = 3'd6;
	localparam logic [2:0] STYLE_BLOCK     = 3'd7;

	localparam logic [2:0] SOURCE_RESET = STYLE_CAMEL;
	localparam logic [2:0] TARGET_RESET = STYLE_SNAKE;

	localparam int unsigned STYLE_W = 3;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	// one classified word character waiting for the back end
	typedef struct packed {
		logic       has_sep;
		logic [7:0] sep;
		logic [7:0] ch;
	} icr_entry_t;

	function automatic logic [7:0] icr_to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [7:0] icr_to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

### rtl/core/icr_front.sv
// ----------------------------------------------------------------------------
// icr_front - input classifier
// takes one byte a cycle while the queue is not full, tracks word breaks and builds queue entries
// ----------------------------------------------------------------------------
module icr_front import icr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_byte,
	input  logic [STYLE_W-1:0] source_style,
	input  logic [STYLE_W-1:0] target_style,
	input  logic               q_full,
	output logic               push,
	output icr_entry_t         entry
);

	logic at_start_q;
	logic gap_seen_q;
	logic accept;
	logic is_nul;
	logic is_upper;
	logic is_lower;
	logic is_digit;
	logic is_word;
	logic brk;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;

	assign is_nul   = (char_byte == CH_NUL);
	assign is_upper = (char_byte >= CH_UPPER_A) && (char_byte <= CH_UPPER_Z);
	assign is_lower = (char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z);
	assign is_digit = (char_byte >= CH_DIGIT_0) && (char_byte <= CH_DIGIT_9);
	assign is_word  = is_upper || is_lower || is_digit;

	// an upper-case letter splits words only in camel or pascal input
	assign brk = gap_seen_q ||
		(((source_style == STYLE_CAMEL) || (source_style == STYLE_PASCAL)) && is_upper);

	assign push = accept && is_word;

	always_comb begin
		entry.has_sep = brk;
		entry.sep     = CH_SPACE;
		entry.ch      = icr_to_lower(char_byte);
		case (target_style)
			STYLE_CAMEL: begin
				entry.has_sep = 1'b0;
				entry.ch = (!at_start_q && brk) ? icr_to_upper(char_byte)
				                                : icr_to_lower(char_byte);
			end
			STYLE_PASCAL: begin
				entry.has_sep = 1'b0;
				entry.ch = (at_start_q || brk) ? icr_to_upper(char_byte)
				                               : icr_to_lower(char_byte);
			end
			STYLE_SNAKE: begin
				entry.sep = CH_UNDERSCORE;
			end
			STYLE_KEBAB: begin
				entry.sep = CH_HYPHEN;
			end
			STYLE_SCREAMING: begin
				entry.sep = CH_UNDERSCORE;
				entry.ch  = icr_to_upper(char_byte);
			end
			STYLE_TITLE: begin
				entry.has_sep = brk && !at_start_q;
				entry.ch = (at_start_q || brk) ? icr_to_upper(char_byte)
				                               : icr_to_lower(char_byte);
			end
			STYLE_LOWER: begin
				entry.sep = CH_SPACE;
			end
			default: begin
				entry.ch = icr_to_upper(char_byte);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			gap_seen_q <= 1'b0;
		end else if (accept) begin
			if (is_nul) begin
				at_start_q <= 1'b1;
				gap_seen_q <= 1'b0;
			end else if (!is_word) begin
				gap_seen_q <= 1'b1;
			end else begin
				at_start_q <= 1'b0;
				gap_seen_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/icr_queue.sv
// ----------------------------------------------------------------------------
// icr_queue - two-entry queue between classifier and emitter
// lets the front keep taking bytes while the back drains separators
// ----------------------------------------------------------------------------
module icr_queue import icr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  icr_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output icr_entry_t head_entry
);

	icr_entry_t  slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

### rtl/core/icr_back.sv
// ----------------------------------------------------------------------------
// icr_back - result emitter
// holds one entry and plays out its optional separator word and its character word
// ----------------------------------------------------------------------------
module icr_back import icr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  icr_entry_t head_entry,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	icr_entry_t hold_q;
	logic       hold_valid_q;
	logic       sep_phase_q;
	logic       fire;

	assign res_valid   = hold_valid_q;
	assign out_byte    = sep_phase_q ? hold_q.sep : hold_q.ch;
	assign last_of_run = !sep_phase_q;
	assign fire        = hold_valid_q && !res_stall;
	assign pop         = head_valid && (!hold_valid_q || (fire && !sep_phase_q));

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q <= head_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			sep_phase_q  <= 1'b0;
		end else if (pop) begin
			hold_valid_q <= 1'b1;
			sep_phase_q  <= head_entry.has_sep;
		end else if (fire) begin
			if (sep_phase_q) begin
				sep_phase_q <= 1'b0;
			end else begin
				hold_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/identifier_case_restyler.sv
// the first output word of a byte passes the queue slot, then the emitter's hold register
// throughput: one input byte a cycle while the queue is not full; the output runs
// one word a cycle while not stalled; a character with a separator takes two words
// gap and terminator bytes are taken but cause no output word
// reset (arst_n low): queue and emitter empty, string state at start, source
// style camel, target style snake
// ----------------------------------------------------------------------------
// identifier_case_restyler - top level
// re-styles an identifier byte stream into another case convention
// ----------------------------------------------------------------------------
module identifier_case_restyler import icr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// byte input
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        char_byte,
	// result output
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_run
);

	logic [STYLE_W-1:0] source_style_q;
	logic [STYLE_W-1:0] target_style_q;
	logic               reg_sel;
	logic               cfg_wr;

	logic               push;
	icr_entry_t         push_entry;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	icr_entry_t         head_entry;

	// register port: registers sit at byte offsets 0 and 4, bit 2 picks one
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_style_q <= SOURCE_RESET;
			target_style_q <= TARGET_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_SOURCE) begin
				source_style_q <= pwdata[STYLE_W-1:0];
			end else begin
				target_style_q <= pwdata[STYLE_W-1:0];
			end
		end
	end

	// read back zero-extended
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_SOURCE) begin
			prdata[STYLE_W-1:0] = source_style_q;
		end else begin
			prdata[STYLE_W-1:0] = target_style_q;
		end
	end

	// front end: classifies each byte and tracks the break state
	icr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.source_style (source_style_q),
		.target_style (target_style_q),
		.q_full       (q_full),
		.push         (push),
		.entry        (push_entry)
	);

	// short queue decoupling intake from the two-word output pattern
	icr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// back end: emits optional separator word then the character word
	icr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

### test/identifier_case_restyler_checker.sv
// ----------------------------------------------------------------------------
// identifier_case_restyler_checker - output checker of the case restyler
// follows register writes and accepted bytes, works out the re-styled output
// words and compares each accepted output word with the oldest one due
// ----------------------------------------------------------------------------
module identifier_case_restyler_checker import icr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              char_valid,
	input  logic              char_stall,
	input  logic [7:0]        char_byte,
	input  logic              res_valid,
	input  logic              res_stall,
	input  logic [7:0]        out_byte,
	input  logic              last_of_run,
	output int                fail_count,
	output int                pending,
	output int                words_checked
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} styled_word_t;

	localparam int REPORT_MAX = 10;

	styled_word_t        restyled_words[$];
	logic [STYLE_W-1:0]  src_style;
	logic [STYLE_W-1:0]  tgt_style;
	logic                at_start;
	logic                gap_seen;
	int                  fails;
	int                  checked;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? (c & ~CASE_OFFSET) : c;
	endfunction

	function automatic logic [7:0] downcase(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
	endfunction

	// one accepted byte: update the string state, queue the words it causes
	task automatic restyle_byte(input logic [7:0] b);
		logic       is_up;
		logic       is_low;
		logic       is_dig;
		logic       brk;
		logic       first;
		logic       has_sep;
		logic [7:0] sep;
		logic [7:0] ch;
		is_up   = (b >= CH_UPPER_A && b <= CH_UPPER_Z);
		is_low  = (b >= CH_LOWER_A && b <= CH_LOWER_Z);
		is_dig  = (b >= CH_DIGIT_0 && b <= CH_DIGIT_9);
		has_sep = 1'b0;
		sep     = CH_UNDERSCORE;
		if (b == CH_NUL) begin
			at_start = 1'b1;
			gap_seen = 1'b0;
		end else if (!(is_up || is_low || is_dig)) begin
			gap_seen = 1'b1;
		end else begin
			brk   = gap_seen ||
				((src_style == STYLE_CAMEL || src_style == STYLE_PASCAL) && is_up);
			first = at_start;
			case (tgt_style)
				STYLE_CAMEL: begin
					ch = (!first && brk) ? upcase(b) : downcase(b);
				end
				STYLE_PASCAL: begin
					ch = (first || brk) ? upcase(b) : downcase(b);
				end
				STYLE_SNAKE: begin
					has_sep = brk;
					ch = downcase(b);
				end
				STYLE_KEBAB: begin
					has_sep = brk;
					sep = CH_HYPHEN;
					ch = downcase(b);
				end
				STYLE_SCREAMING: begin
					has_sep = brk;
					ch = upcase(b);
				end
				STYLE_TITLE: begin
					has_sep = brk && !first;
					sep = CH_SPACE;
					ch = (first || brk) ? upcase(b) : downcase(b);
				end
				STYLE_LOWER: begin
					has_sep = brk;
					sep = CH_SPACE;
					ch = downcase(b);
				end
				default: begin
					has_sep = brk;
					sep = CH_SPACE;
					ch = upcase(b);
				end
			endcase
			if (has_sep) begin
				restyled_words.push_back('{code: sep, last: 1'b0});
			end
			restyled_words.push_back('{code: ch, last: 1'b1});
			at_start = 1'b0;
			gap_seen = 1'b0;
		end
	endtask

	task automatic check_word(input logic [7:0] code, input logic last);
		styled_word_t due;
		if (restyled_words.size() == 0) begin
			fails++;
			if (fails <= REPORT_MAX) begin
				$display("unexpected output word %h last %b, none due", code, last);
			end
		end else begin
			due = restyled_words.pop_front();
			checked++;
			if (due.code !== code || due.last !== last) begin
				fails++;
				if (fails <= REPORT_MAX) begin
					$display("word mismatch: expected %h last %b, got %h last %b",
						due.code, due.last, code, last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restyled_words.delete();
			src_style = SOURCE_RESET;
			tgt_style = TARGET_RESET;
			at_start  = 1'b1;
			gap_seen  = 1'b0;
			fails     = 0;
			checked   = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[ADDR_W-1:2] == REG_SOURCE) begin
					src_style = pwdata[STYLE_W-1:0];
				end else if (paddr[ADDR_W-1:2] == REG_TARGET) begin
					tgt_style = pwdata[STYLE_W-1:0];
				end
			end
			if (char_valid && !char_stall) begin
				restyle_byte(char_byte);
			end
			if (res_valid && !res_stall) begin
				check_word(out_byte, last_of_run);
			end
		end
		fail_count    <= fails;
		pending       <= restyled_words.size();
		words_checked <= checked;
	end

endmodule

### test/identifier_case_restyler_tb.sv
// ----------------------------------------------------------------------------
// identifier_case_restyler_tb - testbench top of the case restyler
// drives directed and random identifier strings under many style settings,
// with random idling on both channels; the checker compares every output word
// ----------------------------------------------------------------------------
module identifier_case_restyler_tb import icr_pkg::*; ();

	localparam int IDLE_PCT     = 27;
	localparam int PHASES       = 14;
	localparam int PHASE_BYTES  = 100;
	localparam int CALM_PHASE   = 7;
	localparam int WATCH_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              char_valid;
	logic              char_stall;
	logic [7:0]        char_byte;
	logic              res_valid;
	logic              res_stall;
	logic [7:0]        out_byte;
	logic              last_of_run;

	int                fail_count;
	int                pending;
	int                words_checked;

	// calm: neither side idles
	logic              calm;
	int                bytes_sent;
	int                settings_used;

	identifier_case_restyler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_byte   (char_byte),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	identifier_case_restyler_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_byte     (char_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// output side back-pressure, off during the calm stretch
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// watchdog: too long with no word moving on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCH_LIMIT) begin
			@(posedge clk);
			if ((char_valid && !char_stall) || (res_valid && !res_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("identifier_case_restyler test failed");
		$finish;
	end

	// one byte over the input channel, with random idle cycles ahead of it;
	// valid stays high afterwards so back-to-back bytes need no gap
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte  <= b;
		@(posedge clk);
		while (char_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// stop sending and let every outstanding word drain before touching registers
	task automatic drain_output();
		char_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	// setup then access cycle; select is dropped by the caller
	task automatic write_reg(input logic idx, input logic [STYLE_W-1:0] val);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[STYLE_W-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
	endtask

	task automatic set_styles(input logic [STYLE_W-1:0] src, input logic [STYLE_W-1:0] tgt);
		drain_output();
		write_reg(REG_SOURCE, src);
		write_reg(REG_TARGET, tgt);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0:       c = CH_UPPER_A + 8'($urandom_range(0, 25));
			1:       c = CH_LOWER_A + 8'($urandom_range(0, 25));
			default: c = CH_DIGIT_0 + 8'($urandom_range(0, 9));
		endcase
		return c;
	endfunction

	// separators, bytes just outside the letter and digit ranges, low control bytes, DEL, high bytes
	function automatic logic [7:0] gap_char();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0:       c = CH_UNDERSCORE;
			1:       c = CH_HYPHEN;
			2:       c = CH_SPACE;
			3:       c = CH_DIGIT_0 - 8'd1;
			4:       c = CH_DIGIT_9 + 8'd1;
			5:       c = CH_UPPER_A - 8'd1;
			6:       c = CH_UPPER_Z + 8'd1;
			7:       c = CH_LOWER_A - 8'd1;
			8:       c = CH_LOWER_Z + 8'd1;
			9:       c = 8'h80 + 8'($urandom_range(0, 127));
			10:      c = 8'h01 + 8'($urandom_range(0, 31));
			default: c = 8'h7F;
		endcase
		return c;
	endfunction

	// mostly well-formed identifiers: words of random case, usually with gap runs between,
	// usually terminated; the rest is raw noise bytes
	task automatic send_identifier();
		int nwords;
		int nchars;
		if ($urandom_range(99) < 15) begin
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				send_byte(gap_char());
			end
			nwords = $urandom_range(1, 4);
			for (int w = 0; w < nwords; w++) begin
				if (w > 0 && $urandom_range(0, 4) != 0) begin
					send_byte(gap_char());
					if ($urandom_range(0, 3) == 0) begin
						send_byte(gap_char());
					end
				end
				nchars = $urandom_range(1, 8);
				for (int c = 0; c < nchars; c++) begin
					send_byte(word_char());
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				send_byte(gap_char());
			end
			if ($urandom_range(0, 9) != 0) begin
				send_byte(CH_NUL);
			end
		end
	endtask

	initial begin : stimulus
		logic [STYLE_W-1:0] src;
		logic [STYLE_W-1:0] tgt;
		int                 target_bytes;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		char_valid    <= 1'b0;
		char_byte     <= CH_NUL;
		calm          <= 1'b0;
		bytes_sent    = 0;
		settings_used = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset styles, camel to snake: separator ahead of the first
		// character is kept, upper case opens a word even at the start,
		// a high byte is a gap
		send_text("-Ab");
		send_byte(8'hFF);
		send_text("z9");
		send_byte(CH_NUL);

		// pascal source into camel: first character lowered, breaks raised
		set_styles(STYLE_PASCAL, STYLE_CAMEL);
		send_text("XyZ@0");
		send_byte(CH_NUL);

		// non-camel source into title: only gaps split, first word no space
		set_styles(STYLE_BLOCK, STYLE_TITLE);
		send_text("a/B:c[");
		send_byte(8'h7F);
		send_text("d{e");
		send_byte(CH_NUL);

		// random part, one style setting per phase, extremes first;
		// every phase boundary drains all outstanding words before writing
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       begin src = STYLE_CAMEL;  tgt = STYLE_CAMEL;  end
				1:       begin src = STYLE_BLOCK;  tgt = STYLE_BLOCK;  end
				2:       begin src = STYLE_CAMEL;  tgt = STYLE_BLOCK;  end
				3:       begin src = STYLE_BLOCK;  tgt = STYLE_CAMEL;  end
				4:       begin src = STYLE_PASCAL; tgt = STYLE_PASCAL; end
				5:       begin src = STYLE_PASCAL; tgt = STYLE_TITLE;  end
				6:       begin src = STYLE_SNAKE;  tgt = STYLE_KEBAB;  end
				default: begin
					src = STYLE_W'($urandom_range(0, 7));
					tgt = STYLE_W'($urandom_range(0, 7));
				end
			endcase
			set_styles(src, tgt);
			calm <= (p == CALM_PHASE);
			target_bytes = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target_bytes) begin
				send_identifier();
			end
		end

		// wind down: wait for every word due before the final report
		char_valid <= 1'b0;
		calm       <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input bytes under %0d style settings",
			bytes_sent, settings_used + 1);
		$display("%0d output words compared, %0d failures", words_checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("identifier_case_restyler test passed");
		end else begin
			$display("identifier_case_restyler test failed");
		end
		$finish;
	end

endmodule
